// File: rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the shell argument tokenizer
// Quote modes, result kinds, tokenizer state and the per-item result bundle.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned MAX_TOKEN_BYTES = 99;
  localparam int unsigned MAX_ARG_SLOTS   = 64;
  localparam int unsigned MAX_RESULTS     = 3;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned NRES_W  = 2;

  localparam logic [CFG_W-1:0] ARG_SLOTS_RESET = CFG_W'(64);

  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_DOUBLE = 2'd2
  } quote_mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END_ARG  = 2'd1,
    KIND_END_LINE = 2'd2
  } kind_e;

  typedef struct packed {
    quote_mode_e        mode;
    logic               plain_esc;
    logic               quoted_esc;
    logic [LEN_W-1:0]   tok_bytes;
    logic [COUNT_W-1:0] num_args;
  } tok_state_t;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] arg_total;
    logic               last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [NRES_W-1:0]         count;
  } step_out_t;

endpackage

// File: rtl/sat_step.sv
// ----------------------------------------------------------------------------
// sat_step: next-state and result logic for one byte or end item
// Decides the bytes to append, whether a token ends, and packs the results.
// ----------------------------------------------------------------------------
module sat_step (
  input  sat_pkg::tok_state_t               state_i,
  input  logic [sat_pkg::BYTE_W-1:0]        byte_i,
  input  logic                              is_end_i,
  input  logic [sat_pkg::CFG_W-1:0]         arg_slots_i,
  output sat_pkg::tok_state_t               state_o,
  output sat_pkg::step_out_t                step_o
);

  logic [sat_pkg::CFG_W-1:0]   slots;
  logic [sat_pkg::COUNT_W-1:0] limit;
  logic                        can_emit;

  // Up to two bytes are appended per item, then an optional token end.
  logic                        a_en, b_en, fin, eol;
  logic [sat_pkg::BYTE_W-1:0]  a_byte, b_byte;
  sat_pkg::tok_state_t         nx;
  logic [sat_pkg::LEN_W-1:0]   len;
  logic [sat_pkg::COUNT_W-1:0] cnt;
  logic [sat_pkg::NRES_W-1:0]  n;
  sat_pkg::step_out_t          so;

  always_comb begin
    slots = (arg_slots_i > sat_pkg::CFG_W'(sat_pkg::MAX_ARG_SLOTS))
          ? sat_pkg::CFG_W'(sat_pkg::MAX_ARG_SLOTS) : arg_slots_i;
    limit = (slots == '0) ? '0 : sat_pkg::COUNT_W'(slots - sat_pkg::CFG_W'(1));
    can_emit = (state_i.num_args < limit);
  end

  always_comb begin
    nx     = state_i;
    a_en   = 1'b0;
    b_en   = 1'b0;
    fin    = 1'b0;
    eol    = 1'b0;
    a_byte = byte_i;
    b_byte = byte_i;
    if (is_end_i) begin
      a_en   = state_i.quoted_esc;
      a_byte = sat_pkg::CH_BSLASH;
      fin    = 1'b1;
      eol    = 1'b1;
    end else if (state_i.plain_esc) begin
      nx.plain_esc = 1'b0;
      a_en         = 1'b1;
    end else if (state_i.quoted_esc) begin
      nx.quoted_esc = 1'b0;
      a_en          = 1'b1;
      if (byte_i != sat_pkg::CH_DQUOTE && byte_i != sat_pkg::CH_BSLASH &&
          byte_i != sat_pkg::CH_DOLLAR) begin
        // Backslash is kept; the byte after it is an ordinary quoted byte.
        a_byte = sat_pkg::CH_BSLASH;
        b_en   = 1'b1;
      end
    end else begin
      case (state_i.mode)
        sat_pkg::MODE_SINGLE: begin
          if (byte_i == sat_pkg::CH_SQUOTE) nx.mode = sat_pkg::MODE_PLAIN;
          else a_en = 1'b1;
        end
        sat_pkg::MODE_DOUBLE: begin
          if (byte_i == sat_pkg::CH_DQUOTE) nx.mode = sat_pkg::MODE_PLAIN;
          else if (byte_i == sat_pkg::CH_BSLASH) nx.quoted_esc = 1'b1;
          else a_en = 1'b1;
        end
        default: begin
          if (byte_i == sat_pkg::CH_SQUOTE) nx.mode = sat_pkg::MODE_SINGLE;
          else if (byte_i == sat_pkg::CH_DQUOTE) nx.mode = sat_pkg::MODE_DOUBLE;
          else if (byte_i == sat_pkg::CH_SPACE) fin = 1'b1;
          else if (byte_i == sat_pkg::CH_BSLASH) nx.plain_esc = 1'b1;
          else a_en = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    so  = '0;
    n   = '0;
    len = state_i.tok_bytes;
    cnt = state_i.num_args;
    if (a_en && len < sat_pkg::LEN_W'(sat_pkg::MAX_TOKEN_BYTES)) begin
      len = len + sat_pkg::LEN_W'(1);
      if (can_emit) begin
        so.res[n].kind     = sat_pkg::KIND_BYTE;
        so.res[n].out_byte = a_byte;
        n = n + sat_pkg::NRES_W'(1);
      end
    end
    if (b_en && len < sat_pkg::LEN_W'(sat_pkg::MAX_TOKEN_BYTES)) begin
      len = len + sat_pkg::LEN_W'(1);
      if (can_emit) begin
        so.res[n].kind     = sat_pkg::KIND_BYTE;
        so.res[n].out_byte = b_byte;
        n = n + sat_pkg::NRES_W'(1);
      end
    end
    if (fin && len != '0 && can_emit) begin
      so.res[n].kind = sat_pkg::KIND_END_ARG;
      n   = n + sat_pkg::NRES_W'(1);
      cnt = cnt + sat_pkg::COUNT_W'(1);
      len = '0;
    end
    if (eol) begin
      so.res[n].kind      = sat_pkg::KIND_END_LINE;
      so.res[n].arg_total = cnt;
      n = n + sat_pkg::NRES_W'(1);
    end
    if (n != '0) so.res[n - sat_pkg::NRES_W'(1)].last = 1'b1;
    so.count = n;

    state_o           = nx;
    state_o.tok_bytes = len;
    state_o.num_args  = cnt;
    if (eol) begin
      // End of line returns the tokenizer to its idle state.
      state_o = '0;
    end
    step_o = so;
  end

endmodule

// File: rtl/sat_outbuf.sv
// ----------------------------------------------------------------------------
// sat_outbuf: result register of the tokenizer
// Holds the up to three results of one item and presents them in order.
// ----------------------------------------------------------------------------
module sat_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sat_pkg::step_out_t step_i,
  input  logic               ready_i,
  output logic               free_o,
  output logic               valid_o,
  output sat_pkg::result_t   res_o
);

  sat_pkg::result_t [sat_pkg::MAX_RESULTS-1:0] res_q;
  logic [sat_pkg::NRES_W-1:0] cnt_q, ptr_q;

  assign valid_o = (ptr_q < cnt_q);
  // Free when empty or once the last stored result leaves in this cycle.
  assign free_o  = !valid_o || (ready_i && ptr_q == cnt_q - sat_pkg::NRES_W'(1));

  always_comb begin
    case (ptr_q)
      2'd0:    res_o = res_q[0];
      2'd1:    res_o = res_q[1];
      2'd2:    res_o = res_q[2];
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else if (load_i) begin
      cnt_q <= step_i.count;
      ptr_q <= '0;
    end else if (valid_o && ready_i) begin
      ptr_q <= ptr_q + sat_pkg::NRES_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= step_i.res;
    end
  end

endmodule

// File: rtl/shell_argument_tokenizer.sv
// Flow: an accepted item waits in the input register until the result register is
// free; its results are then loaded into the result register and presented there.
// Throughput: one item per cycle while each item gives at most one result and the
// receiver is ready; an item with two or three results holds the single output
// port until all of them have been taken.
// Reset: rst_ni clears the tokenizer state and buffers and sets the slot count to 64.
// ----------------------------------------------------------------------------
// shell_argument_tokenizer: streaming command line argument splitter
// Takes one byte per item and emits argument bytes, argument ends and a line
// end with the argument count. Quotes and backslash escapes follow shell rules.
// ----------------------------------------------------------------------------
module shell_argument_tokenizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: argument slot count write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sat_pkg::CFG_W-1:0]    cfg_data_i,
  // Input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] byte_value
  input  logic                         s_axis_tlast,  // is_end
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // [7:0] out_byte, [13:8] arg_total
  output logic [1:0]                   m_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tlast   // last
);

  // Config register: writes must come only while the block is idle; not enforced here.
  logic [sat_pkg::CFG_W-1:0] arg_slots_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_slots_q <= sat_pkg::ARG_SLOTS_RESET;
    end else if (cfg_valid_i) begin
      arg_slots_q <= cfg_data_i;
    end
  end

  // Input register. It takes a new item when empty or when its content moves on
  // in the same cycle: one item per cycle while the result register is free.
  logic                       in_valid_q;
  logic [sat_pkg::BYTE_W-1:0] in_byte_q;
  logic                       in_end_q;
  logic                       buf_free;
  logic                       fire;

  assign fire          = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Tokenizer state: quote mode, pending escapes, token length and count.
  sat_pkg::tok_state_t state_q, state_d;
  sat_pkg::step_out_t  step;

  sat_step u_step (
    .state_i     (state_q),
    .byte_i      (in_byte_q),
    .is_end_i    (in_end_q),
    .arg_slots_i (arg_slots_q),
    .state_o     (state_d),
    .step_o      (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register: results leave one per cycle while the receiver is ready.
  sat_pkg::result_t res;

  sat_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .step_i  (step),
    .ready_i (m_axis_tready),
    .free_o  (buf_free),
    .valid_o (m_axis_tvalid),
    .res_o   (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {2'b00, res.arg_total, res.out_byte};
  assign m_axis_tlast = res.last;

`ifndef NO_ASSERTIONS
  // A line end is always the final result of its item.
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == sat_pkg::KIND_END_LINE |-> m_axis_tlast)
    else $error("line end result without last flag");

  // An end item leaves the tokenizer idle.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_end_q |=> state_q == '0)
    else $error("tokenizer state not cleared after end item");

  // Only argument bytes carry a nonzero byte field.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != sat_pkg::KIND_BYTE |-> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero byte on a non-byte result");
`endif

endmodule

// File: test/shell_argument_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_argument_tokenizer_checker: result predictor and scoreboard
// Watches the configuration, input and result channels of the tokenizer. It
// keeps its own copy of the tokenizer state, works out the results of every
// accepted item and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module shell_argument_tokenizer_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [sat_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] byte_value
  input  logic                      s_axis_tlast,   // is_end
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [15:0]               m_axis_tdata,   // [7:0] out_byte, [13:8] arg_total
  input  logic [1:0]                m_axis_tuser,   // [1:0] kind
  input  logic                      m_axis_tlast,
  output int                        mismatch_count_o,
  output int                        pending_o
);

  logic [sat_pkg::CFG_W-1:0]   arg_slots_q;
  sat_pkg::quote_mode_e        quote_mode_q;
  logic                        plain_esc_q;
  logic                        quoted_esc_q;
  logic [sat_pkg::LEN_W-1:0]   tok_bytes_q;
  logic [sat_pkg::COUNT_W-1:0] num_args_q;

  sat_pkg::result_t expected_tokens[$];
  sat_pkg::result_t item_results[$];
  int               mismatch_total = 0;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  function automatic logic [sat_pkg::CFG_W-1:0] arg_limit();
    logic [sat_pkg::CFG_W-1:0] slots;
    slots = (arg_slots_q > sat_pkg::MAX_ARG_SLOTS) ?
            sat_pkg::CFG_W'(sat_pkg::MAX_ARG_SLOTS) : arg_slots_q;
    return (slots == '0) ? '0 : slots - 1'b1;
  endfunction

  function automatic void add_result(sat_pkg::kind_e kind, logic [7:0] b,
                                     logic [sat_pkg::COUNT_W-1:0] total);
    sat_pkg::result_t r;
    r.kind      = kind;
    r.out_byte  = b;
    r.arg_total = total;
    r.last      = 1'b0;
    item_results.push_back(r);
  endfunction

  // Bytes past the truncation bound vanish; bytes past the argument limit
  // still grow the token but are not shown.
  function automatic void take_char(logic [7:0] c);
    if (tok_bytes_q < sat_pkg::MAX_TOKEN_BYTES) begin
      tok_bytes_q = tok_bytes_q + 1'b1;
      if (num_args_q < arg_limit()) add_result(sat_pkg::KIND_BYTE, c, '0);
    end
  endfunction

  function automatic void close_token();
    if (tok_bytes_q != '0 && num_args_q < arg_limit()) begin
      add_result(sat_pkg::KIND_END_ARG, '0, '0);
      num_args_q  = num_args_q + 1'b1;
      tok_bytes_q = '0;
    end
  endfunction

  function automatic void scan_char(logic [7:0] c);
    case (quote_mode_q)
      sat_pkg::MODE_SINGLE: begin
        if (c == sat_pkg::CH_SQUOTE) quote_mode_q = sat_pkg::MODE_PLAIN;
        else take_char(c);
      end
      sat_pkg::MODE_DOUBLE: begin
        if (c == sat_pkg::CH_DQUOTE) quote_mode_q = sat_pkg::MODE_PLAIN;
        else if (c == sat_pkg::CH_BSLASH) quoted_esc_q = 1'b1;
        else take_char(c);
      end
      default: begin
        if (c == sat_pkg::CH_SQUOTE) quote_mode_q = sat_pkg::MODE_SINGLE;
        else if (c == sat_pkg::CH_DQUOTE) quote_mode_q = sat_pkg::MODE_DOUBLE;
        else if (c == sat_pkg::CH_SPACE) close_token();
        else if (c == sat_pkg::CH_BSLASH) plain_esc_q = 1'b1;
        else take_char(c);
      end
    endcase
  endfunction

  function automatic void clear_line();
    quote_mode_q = sat_pkg::MODE_PLAIN;
    plain_esc_q  = 1'b0;
    quoted_esc_q = 1'b0;
    tok_bytes_q  = '0;
    num_args_q   = '0;
  endfunction

  function automatic void tokenize_item(logic [7:0] c, logic is_end);
    item_results.delete();
    if (is_end) begin
      if (quoted_esc_q) take_char(sat_pkg::CH_BSLASH);
      if (tok_bytes_q != '0 && num_args_q < arg_limit()) begin
        add_result(sat_pkg::KIND_END_ARG, '0, '0);
        num_args_q = num_args_q + 1'b1;
      end
      add_result(sat_pkg::KIND_END_LINE, '0, num_args_q);
      clear_line();
    end else if (plain_esc_q) begin
      plain_esc_q = 1'b0;
      take_char(c);
    end else if (quoted_esc_q) begin
      quoted_esc_q = 1'b0;
      if (c == sat_pkg::CH_DQUOTE || c == sat_pkg::CH_BSLASH ||
          c == sat_pkg::CH_DOLLAR) begin
        take_char(c);
      end else begin
        take_char(sat_pkg::CH_BSLASH);
        scan_char(c);
      end
    end else begin
      scan_char(c);
    end
    if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
    foreach (item_results[i]) expected_tokens.push_back(item_results[i]);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_total++;
    if (mismatch_total <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sat_pkg::result_t exp_res;
    if (!rst_ni) begin
      arg_slots_q = sat_pkg::ARG_SLOTS_RESET;
      clear_line();
      expected_tokens.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) arg_slots_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) tokenize_item(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch($sformatf("result with nothing due: kind %0d tdata %h last %b",
                                  m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          exp_res = expected_tokens.pop_front();
          if (m_axis_tuser != exp_res.kind || m_axis_tdata[7:0] != exp_res.out_byte ||
              m_axis_tdata[13:8] != exp_res.arg_total || m_axis_tdata[15:14] != 2'b00 ||
              m_axis_tlast != exp_res.last) begin
            flag_mismatch($sformatf(
              "expected kind %0d byte %h total %0d last %b, got kind %0d tdata %h last %b",
              exp_res.kind, exp_res.out_byte, exp_res.arg_total, exp_res.last,
              m_axis_tuser, m_axis_tdata, m_axis_tlast));
          end
        end
      end
    end
    mismatch_count_o <= mismatch_total;
    pending_o        <= expected_tokens.size();
  end

endmodule

// File: test/shell_argument_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_argument_tokenizer_tb: top level of the tokenizer testbench
// Feeds command lines byte by byte, changes the argument slot count between
// phases and leaves all checking to the checker instance, then reports the
// verdict.
// ----------------------------------------------------------------------------
module shell_argument_tokenizer_tb;

  // Every stall is short, so a long stretch without a single handshake on any
  // channel means the block has hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // An accepted item passes the input register and the result register before its
  // first result appears. After the last result the testbench lets the block settle
  // before touching the argument slot count.
  localparam int SETTLE_CYCLES  = 8;

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [sat_pkg::CFG_W-1:0] cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;   // [7:0] byte_value
  logic                      s_axis_tlast  = 1'b0; // is_end
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [15:0]               m_axis_tdata;         // [7:0] out_byte, [13:8] arg_total
  logic [1:0]                m_axis_tuser;         // [1:0] kind
  logic                      m_axis_tlast;

  int mismatch_count;
  int results_due;
  int quiet_cycles = 0;
  int phase_items;
  int sink_stall   = 0;
  bit idle_on      = 1'b1;

  shell_argument_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  shell_argument_tokenizer_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: the receiver drops ready in short random bursts while idling
  // is enabled and keeps it high for good once the final phase starts.
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      sink_stall = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // The watchdog restarts on any handshake and ends the run when none has
  // happened for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one item and returns at the edge where it is accepted. The valid
  // is left high so that back-to-back items follow without a gap.
  task automatic send_char(input logic [7:0] b, input logic is_end);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    phase_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // The byte that travels with the end item is ignored by the block, so it is
  // random to toggle every data bit on end items too.
  task automatic end_line();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Holds the sender off until every result due has been accepted, then lets
  // the block run dry for the settling period.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_arg_slots(input logic [sat_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    phase_items = 0;
  endtask

  // Mostly word characters and separators, with enough quotes, backslashes
  // and dollar signs to walk through every quoting state, plus raw bytes.
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 65) return sat_pkg::CH_SPACE;
    if (r < 72) return sat_pkg::CH_SQUOTE;
    if (r < 79) return sat_pkg::CH_DQUOTE;
    if (r < 87) return sat_pkg::CH_BSLASH;
    if (r < 90) return sat_pkg::CH_DOLLAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Random command lines of mixed length, each closed by an end item, until
  // the phase has used up its share of items.
  task automatic random_lines(input int budget);
    int len;
    while (phase_items < budget) begin
      len = $urandom_range(0, 16);
      for (int i = 0; i < len; i++) send_char(pick_char(), 1'b0);
      end_line();
    end
  endtask

  initial begin
    phase_items = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the reset slot count. The first has an escaped
    // space outside quotes and a quoted space in single quotes.
    send_text("a\\ b 'x y'");
    end_line();
    // Double-quote escapes of a quote, a dollar sign and a backslash, a
    // backslash kept before an ordinary byte, and a backslash still pending
    // in an unclosed double quote when the line ends.
    send_text("\"\\\"\\$\\\\\\q\\");
    end_line();
    // The zero byte and the all-ones byte are ordinary argument bytes, and a
    // plain backslash pending at the end of the line is dropped.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(sat_pkg::CH_BSLASH, 1'b0);
    end_line();
    // An empty line reports zero arguments.
    end_line();

    random_lines(40);

    // A tight limit: only one argument per line may appear.
    set_arg_slots(7'd2);
    random_lines(16);

    // No argument slots at all; every line reports zero.
    set_arg_slots(7'd0);
    random_lines(16);

    // One slot is only the terminator, so again no argument is emitted.
    set_arg_slots(7'd1);
    random_lines(16);

    // The largest value is clamped to the slot count. The over-long token is
    // cut at the truncation bound before a short second argument.
    set_arg_slots(7'd127);
    for (int i = 0; i < 101; i++) send_char(8'h6B, 1'b0);
    send_text(" m");
    end_line();
    random_lines(16);

    set_arg_slots(7'd3);
    random_lines(16);

    set_arg_slots(sat_pkg::ARG_SLOTS_RESET);
    random_lines(16);

    // The final phase runs without any idling on either side.
    set_arg_slots(7'($urandom_range(1, 127)));
    idle_on = 1'b0;
    random_lines(24);

    drain_results();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
